@@ sv/ipimb_pkg.sv @@
// ipimb_pkg: shared types and constants of the IPI mailbox register block.
// No dependencies; used by every module.
package ipimb_pkg;

    // Default sizing of the block.
    localparam int NODE_COUNT_DEF     = 4;
    localparam int CORES_PER_NODE_DEF = 4;
    localparam int MAILBOX_BYTES_DEF  = 32;

    // Fixed storage geometry: 16 core slots, four 64-bit mailbox words each.
    localparam int CORE_SLOTS = 16;
    localparam int MBOX_WORDS = 64;

    // Register offsets within a core's page.
    localparam logic [7:0] OFF_STATUS = 8'h00;
    localparam logic [7:0] OFF_ENABLE = 8'h04;
    localparam logic [7:0] OFF_SET    = 8'h08;
    localparam logic [7:0] OFF_CLEAR  = 8'h0c;
    localparam logic [7:0] OFF_MBOX   = 8'h20;

    // Access error codes.
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_OFFSET = 2'd1;
    localparam logic [1:0] ERR_ALIGN  = 2'd2;

    localparam logic [5:0] NODE_POS_RESET = 6'd44;

    typedef struct packed {
        logic        operation;
        logic [47:0] address;
        logic [1:0]  access_size;
        logic [63:0] write_data;
    } t_req;

    typedef struct packed {
        logic [63:0] read_data;
        logic        raise_interrupt;
        logic        lower_interrupt;
        logic [3:0]  target_core;
        logic [1:0]  access_error;
    } t_rsp;

    typedef struct packed {
        logic capture;   // take the offered access into the request register
        logic commit;    // apply the access and load the result register
        logic load_mem;  // load the result register with mailbox read data
    } t_ctrl_cmd;

    typedef struct packed {
        logic mbox_read; // held access is a good mailbox read
        logic out_free;  // result register can take a new transfer
    } t_ctrl_stat;

endpackage

@@ sv/ipimb_chan_if.sv @@
// ipimb_chan_if: valid/ready channel carrying one payload per transfer.
// Payload type is supplied by the user, normally from ipimb_pkg.
interface ipimb_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/ipimb_ctrl.sv @@
// ipimb_ctrl: sequencing state machine of the IPI mailbox block.
// Depends on ipimb_pkg for the command and status structs.
module ipimb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ipimb_pkg::t_ctrl_stat i_stat,
    output ipimb_pkg::t_ctrl_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_MEM  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.commit   = 1'b0;
        o_cmd.load_mem = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // mailbox reads pass through S_MEM to wait for the registered RAM output
                if (i_stat.mbox_read) begin
                    n_state = S_MEM;
                end else if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_MEM: begin
                if (i_stat.out_free) begin
                    o_cmd.load_mem = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/ipimb_datapath.sv @@
// ipimb_datapath: request register, address decode, per-core registers,
// mailbox RAM and result register. Depends on ipimb_pkg.
module ipimb_datapath #(
    parameter int NODE_COUNT     = ipimb_pkg::NODE_COUNT_DEF,
    parameter int CORES_PER_NODE = ipimb_pkg::CORES_PER_NODE_DEF,
    parameter int MAILBOX_BYTES  = ipimb_pkg::MAILBOX_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ipimb_pkg::t_ctrl_cmd  i_cmd,
    output ipimb_pkg::t_ctrl_stat o_stat,
    input  ipimb_pkg::t_req       i_req,
    input  logic                  i_cfg_valid,
    input  logic [5:0]            i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output ipimb_pkg::t_rsp       o_out
);

    localparam logic [8:0] MBOX_LAST  = 9'(32'(ipimb_pkg::OFF_MBOX) + MAILBOX_BYTES - 4);
    localparam logic [8:0] MBOX_LIMIT = 9'(MAILBOX_BYTES);

    ipimb_pkg::t_req r_req;
    logic [5:0]      r_node_pos;

    logic [31:0] r_status [ipimb_pkg::CORE_SLOTS];
    logic [31:0] r_enable [ipimb_pkg::CORE_SLOTS];

    logic [63:0] r_mbox [ipimb_pkg::MBOX_WORDS];
    logic        r_mbox_vld [ipimb_pkg::MBOX_WORDS];
    logic [63:0] r_mem_q;
    logic        r_mem_vld_q;

    logic            r_out_valid;
    ipimb_pkg::t_rsp r_out;
    ipimb_pkg::t_rsp n_out;

    // decode of the held access
    logic [7:0]  w_off;
    logic [1:0]  w_core;
    logic [1:0]  w_node;
    logic [47:0] w_node_bits;
    logic [63:0] w_size_mask;
    logic [63:0] w_data;
    logic [3:0]  w_len;
    logic        w_misaligned;
    logic        w_absent;
    logic        w_in_mbox;
    logic [7:0]  w_base;
    logic [2:0]  w_lane_lo;
    logic [3:0]  w_tgt;
    logic [5:0]  w_word;
    logic [1:0]  w_err;
    logic        w_is_mbox;
    logic        w_wr;
    logic [63:0] w_rd;
    logic        w_raise;
    logic        w_lower;
    logic [31:0] w_status_clr;
    logic [7:0]  w_lane_en;
    logic [63:0] w_lane_data;
    logic        w_mbox_we;
    logic [63:0] w_mem_rd;

    always_comb begin
        w_off        = r_req.address[7:0];
        w_core       = r_req.address[9:8];
        w_node_bits  = r_req.address >> r_node_pos;
        w_node       = w_node_bits[1:0];
        w_wr         = r_req.operation;
        w_len        = 4'd1 << r_req.access_size;
        case (r_req.access_size)
            2'd0:    w_size_mask = 64'h0000_0000_0000_00ff;
            2'd1:    w_size_mask = 64'h0000_0000_0000_ffff;
            2'd2:    w_size_mask = 64'h0000_0000_ffff_ffff;
            default: w_size_mask = '1;
        endcase
        w_data       = r_req.write_data & w_size_mask;
        w_misaligned = (w_off & (8'(w_len) - 8'd1)) != 8'd0;
        w_absent     = (int'(w_core) >= CORES_PER_NODE) || (int'(w_node) >= NODE_COUNT);
        w_base       = w_off - ipimb_pkg::OFF_MBOX;
        w_lane_lo    = w_base[2:0];
        w_in_mbox    = (w_off >= ipimb_pkg::OFF_MBOX) && ({1'b0, w_off} <= MBOX_LAST)
                       && ((9'(w_base) + 9'(w_len)) <= MBOX_LIMIT);

        w_tgt = 4'd0;
        if (!w_misaligned && !w_absent) begin
            w_tgt = 4'(int'(w_node) * CORES_PER_NODE + int'(w_core));
        end
        w_word = {w_tgt, w_base[4:3]};

        w_err     = ipimb_pkg::ERR_OK;
        w_is_mbox = 1'b0;
        if (w_misaligned) begin
            w_err = ipimb_pkg::ERR_ALIGN;
        end else if (w_absent) begin
            w_err = ipimb_pkg::ERR_OFFSET;
        end else if (w_off == ipimb_pkg::OFF_STATUS || w_off == ipimb_pkg::OFF_ENABLE
                     || w_off == ipimb_pkg::OFF_SET || w_off == ipimb_pkg::OFF_CLEAR) begin
            w_err = ipimb_pkg::ERR_OK;
        end else if (w_in_mbox) begin
            w_is_mbox = 1'b1;
        end else begin
            w_err = ipimb_pkg::ERR_OFFSET;
        end

        w_status_clr = r_status[w_tgt] & ~w_data[31:0];
        w_rd         = '0;
        w_raise      = 1'b0;
        w_lower      = 1'b0;
        if (w_err == ipimb_pkg::ERR_OK && !w_is_mbox) begin
            case (w_off)
                ipimb_pkg::OFF_STATUS: w_rd = w_wr ? 64'd0 : {32'd0, r_status[w_tgt]};
                ipimb_pkg::OFF_ENABLE: w_rd = w_wr ? 64'd0 : {32'd0, r_enable[w_tgt]};
                ipimb_pkg::OFF_SET:    w_raise = w_wr;
                ipimb_pkg::OFF_CLEAR:  w_lower = w_wr && (w_status_clr == 32'd0);
                default:               w_rd = '0;
            endcase
        end

        for (int l = 0; l < 8; l++) begin
            w_lane_en[l] = (4'(l) >= {1'b0, w_lane_lo}) && (4'(l) < ({1'b0, w_lane_lo} + w_len));
        end
        w_lane_data = w_data << {w_lane_lo, 3'b000};
        w_mbox_we   = i_cmd.commit && w_is_mbox && w_wr;
        w_mem_rd    = r_mem_vld_q ? ((r_mem_q >> {w_lane_lo, 3'b000}) & w_size_mask) : 64'd0;
    end

    assign o_stat.mbox_read = w_is_mbox && !w_wr;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // request and configuration registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_pos <= ipimb_pkg::NODE_POS_RESET;
        end else if (i_cfg_valid) begin
            r_node_pos <= i_cfg_data;
        end
    end

    // per-core status and enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < ipimb_pkg::CORE_SLOTS; c++) begin
                r_status[c] <= '0;
                r_enable[c] <= '0;
            end
        end else if (i_cmd.commit && w_wr && w_err == ipimb_pkg::ERR_OK && !w_is_mbox) begin
            case (w_off)
                ipimb_pkg::OFF_ENABLE: r_enable[w_tgt] <= w_data[31:0];
                ipimb_pkg::OFF_SET:    r_status[w_tgt] <= r_status[w_tgt] | w_data[31:0];
                ipimb_pkg::OFF_CLEAR:  r_status[w_tgt] <= w_status_clr;
                default:               r_status[w_tgt] <= r_status[w_tgt];
            endcase
        end
    end

    // mailbox RAM: byte-lane writes; a never-written word takes zeros in the
    // lanes outside the access so the valid bit can be set
    always_ff @(posedge i_clk) begin
        if (w_mbox_we) begin
            for (int l = 0; l < 8; l++) begin
                if (w_lane_en[l]) begin
                    r_mbox[w_word][l*8 +: 8] <= w_lane_data[l*8 +: 8];
                end else if (!r_mbox_vld[w_word]) begin
                    r_mbox[w_word][l*8 +: 8] <= 8'd0;
                end
            end
        end
        r_mem_q <= r_mbox[w_word];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < ipimb_pkg::MBOX_WORDS; w++) begin
                r_mbox_vld[w] <= 1'b0;
            end
            r_mem_vld_q <= 1'b0;
        end else begin
            if (w_mbox_we) begin
                r_mbox_vld[w_word] <= 1'b1;
            end
            r_mem_vld_q <= r_mbox_vld[w_word];
        end
    end

    // result register
    always_comb begin
        n_out.read_data       = i_cmd.load_mem ? w_mem_rd : w_rd;
        n_out.raise_interrupt = w_raise;
        n_out.lower_interrupt = w_lower;
        n_out.target_core     = w_tgt;
        n_out.access_error    = w_err;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit || i_cmd.load_mem) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit || i_cmd.load_mem) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ sv/ipi_mailbox_register_block.sv @@
// ipi_mailbox_register_block: top level of the IPI mailbox register block.
// Depends on ipimb_pkg, ipimb_chan_if, ipimb_ctrl and ipimb_datapath.
//
// Inter-processor interrupt mailbox for up to NODE_COUNT x CORES_PER_NODE
// cores. Each transfer on i_req is one bus access; each gives exactly one
// transfer on o_rsp, in order. The node comes from two address bits starting
// at the position held in the configuration register (written through i_cfg,
// always ready, reset 44), the core from address bits 9:8, the register from
// the low byte: status (read only), enable, set (ORs into status, raises the
// interrupt), clear (lowers it when status ends zero) and a byte-lane
// mailbox from offset 0x20. Misaligned and unknown accesses are flagged and
// change nothing. An access is taken in the idle state and its result loaded
// into the output register from the execute state once that register is free;
// mailbox reads first wait in a further state, since the mailbox RAM has a
// registered read port. A new access waits until the last one is loaded.
// A result waiting in the output register does not block the next access;
// only a second result waiting behind it does. Mailbox words carry per-word
// valid bits cleared by reset, so no clearing pass is needed after reset.
module ipi_mailbox_register_block #(
    parameter int NODE_COUNT     = ipimb_pkg::NODE_COUNT_DEF,
    parameter int CORES_PER_NODE = ipimb_pkg::CORES_PER_NODE_DEF,
    parameter int MAILBOX_BYTES  = ipimb_pkg::MAILBOX_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ipimb_chan_if.sink   i_req,
    ipimb_chan_if.source o_rsp,
    ipimb_chan_if.sink   i_cfg
);

    ipimb_pkg::t_ctrl_cmd  w_cmd;
    ipimb_pkg::t_ctrl_stat w_stat;
    logic                  w_in_ready;

    // configuration writes are always taken
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = w_in_ready;

    ipimb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ipimb_datapath #(
        .NODE_COUNT     (NODE_COUNT),
        .CORES_PER_NODE (CORES_PER_NODE),
        .MAILBOX_BYTES  (MAILBOX_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_req       (i_req.payload),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.payload),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_out       (o_rsp.payload)
    );

endmodule
